/* hdl/ihw_pkg.sv */
package ihw_pkg;

  // Request selector as it arrives on tuser
  typedef enum logic [1:0] {
    REQ_DATA   = 2'd0,
    REQ_ORIGIN = 2'd1,
    REQ_END    = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  // Command kinds passed from the front end to the record engine
  typedef enum logic [1:0] {
    CMD_DATA   = 2'd0,
    CMD_ORIGIN = 2'd1,
    CMD_END    = 2'd2
  } cmd_e;

  typedef struct packed {
    cmd_e        kind;
    logic [7:0]  data;
    logic [15:0] org_addr;
    logic [7:0]  org_sum;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COLON,
    ST_COUNT,
    ST_ADDR_HI,
    ST_ADDR_LO,
    ST_TYPE,
    ST_DATA,
    ST_CHECK,
    ST_CR,
    ST_LF,
    ST_EOF_REC,
    ST_EOF_CR,
    ST_EOF_LF,
    ST_EOF_MARK
  } state_e;

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_EOF   = 8'h1A;

  localparam logic [7:0] REC_TYPE_DATA = 8'h00;
  // Zeros that follow the colon of the end-of-file record
  localparam logic [3:0] EOF_ZEROS = 4'd10;

  localparam logic [2:0] REG_CRLF_ADDR = 3'd0;

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    logic [7:0] r;
    if (v < 4'd10) begin
      r = {4'h3, v};
    end else begin
      r = 8'h37 + {4'h0, v};
    end
    return r;
  endfunction

  function automatic logic [7:0] addr_sum(input logic [15:0] a);
    return a[15:8] + a[7:0];
  endfunction

endpackage

/* hdl/ihw_front.sv */
module ihw_front (
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [1:0]          s_axis_tuser,  // [1:0] req_type
  input  logic [23:0]         s_axis_tdata,  // [7:0] data_byte, [23:8] address
  output logic                push_valid_o,
  input  logic                push_ready_i,
  output ihw_pkg::cmd_t       push_cmd_o
);
  import ihw_pkg::*;

  req_e        req;
  logic [15:0] addr;
  logic [15:0] org;

  assign req  = req_e'(s_axis_tuser);
  assign addr = s_axis_tdata[23:8];

  assign s_axis_tready = push_ready_i;

  always_comb begin
    push_valid_o       = 1'b0;
    push_cmd_o.kind    = CMD_DATA;
    org                = 16'd0;
    case (req)
      REQ_DATA: begin
        push_valid_o    = s_axis_tvalid;
        push_cmd_o.kind = CMD_DATA;
        // origin of the next record if this byte completes one
        org             = addr + 16'd1;
      end
      REQ_ORIGIN: begin
        push_valid_o    = s_axis_tvalid;
        push_cmd_o.kind = CMD_ORIGIN;
        org             = addr;
      end
      REQ_END: begin
        push_valid_o    = s_axis_tvalid;
        push_cmd_o.kind = CMD_END;
        org             = 16'd0;
      end
      default: begin
        // unused selector: take the transfer and drop it
        push_valid_o = 1'b0;
      end
    endcase
    push_cmd_o.data     = s_axis_tdata[7:0];
    push_cmd_o.org_addr = org;
    push_cmd_o.org_sum  = addr_sum(org);
  end

endmodule

/* hdl/ihw_fifo.sv */
module ihw_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  ihw_pkg::cmd_t push_cmd_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output ihw_pkg::cmd_t pop_cmd_o
);
  import ihw_pkg::*;

  cmd_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] level_q, level_d;
  logic       push, pop;

  assign push_ready_o = (level_q != 2'd2);
  assign pop_valid_o  = (level_q != 2'd0);
  assign pop_cmd_o    = slot_q[rd_ptr_q];

  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    level_d  = level_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      level_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

/* hdl/ihw_back.sv */
module ihw_back #(
  parameter int RECORD_BYTES = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          crlf_i,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  input  ihw_pkg::cmd_t cmd_i,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [7:0]    m_axis_tdata,  // [7:0] out_char
  output logic          m_axis_tlast
);
  import ihw_pkg::*;

  localparam int IdxW = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;
  localparam int CntW = $clog2(RECORD_BYTES + 1);

  state_e            state_q, state_d;
  logic              nib_q, nib_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [3:0]        eof_cnt_q, eof_cnt_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [15:0]       addr_q, addr_d;
  logic [7:0]        sum_q, sum_d;
  logic [15:0]       org_addr_q, org_addr_d;
  logic [7:0]        org_sum_q, org_sum_d;
  logic              end_q, end_d;

  logic [7:0]        mem_q [RECORD_BYTES];
  logic [7:0]        rd_q;
  logic              wr_en;

  logic              ov_q;
  logic [7:0]        oc_q;
  logic              ol_q;

  logic              emit, emit_last, adv, fire;
  logic [7:0]        emit_char;
  logic [7:0]        cur_byte;
  logic [7:0]        chk;

  assign chk  = 8'd0 - sum_q - 8'(cnt_q);
  assign adv  = !ov_q || m_axis_tready;
  assign fire = emit && adv;

  assign cmd_ready_o   = (state_q == ST_IDLE);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = oc_q;
  assign m_axis_tlast  = ol_q;

  // Character for the current sequencer position
  always_comb begin
    emit      = 1'b1;
    emit_last = 1'b0;
    cur_byte  = REC_TYPE_DATA;
    case (state_q)
      ST_COUNT:   cur_byte = 8'(cnt_q);
      ST_ADDR_HI: cur_byte = addr_q[15:8];
      ST_ADDR_LO: cur_byte = addr_q[7:0];
      ST_DATA:    cur_byte = rd_q;
      ST_CHECK:   cur_byte = chk;
      default:    cur_byte = REC_TYPE_DATA;
    endcase
    emit_char = hex_char(nib_q ? cur_byte[3:0] : cur_byte[7:4]);
    case (state_q)
      ST_IDLE:     emit = 1'b0;
      ST_COLON:    emit_char = CHAR_COLON;
      ST_CR:       emit_char = CHAR_CR;
      ST_LF: begin
        emit_char = CHAR_LF;
        emit_last = !end_q;
      end
      ST_EOF_REC:  emit_char = (eof_cnt_q == 4'd0) ? CHAR_COLON : CHAR_ZERO;
      ST_EOF_CR:   emit_char = CHAR_CR;
      ST_EOF_LF:   emit_char = CHAR_LF;
      ST_EOF_MARK: begin
        emit_char = CHAR_EOF;
        emit_last = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d    = state_q;
    nib_d      = nib_q;
    idx_d      = idx_q;
    eof_cnt_d  = eof_cnt_q;
    cnt_d      = cnt_q;
    addr_d     = addr_q;
    sum_d      = sum_q;
    org_addr_d = org_addr_q;
    org_sum_d  = org_sum_q;
    end_d      = end_q;
    wr_en      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        nib_d     = 1'b0;
        idx_d     = '0;
        eof_cnt_d = 4'd0;
        if (cmd_valid_i) begin
          org_addr_d = cmd_i.org_addr;
          org_sum_d  = cmd_i.org_sum;
          end_d      = (cmd_i.kind == CMD_END);
          case (cmd_i.kind)
            CMD_DATA: begin
              wr_en = 1'b1;
              cnt_d = cnt_q + CntW'(1);
              sum_d = sum_q + cmd_i.data;
              if (cnt_q + CntW'(1) == CntW'(RECORD_BYTES)) begin
                state_d = ST_COLON;
              end
            end
            CMD_ORIGIN, CMD_END: begin
              if (cnt_q == '0) begin
                // nothing buffered: take the new origin at once
                addr_d  = cmd_i.org_addr;
                sum_d   = cmd_i.org_sum;
                state_d = (cmd_i.kind == CMD_END) ? ST_EOF_REC : ST_IDLE;
              end else begin
                state_d = ST_COLON;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_COLON: begin
        if (fire) begin
          state_d = ST_COUNT;
        end
      end
      ST_COUNT, ST_ADDR_HI, ST_ADDR_LO, ST_TYPE, ST_DATA, ST_CHECK: begin
        if (fire) begin
          nib_d = !nib_q;
          if (nib_q) begin
            case (state_q)
              ST_COUNT:   state_d = ST_ADDR_HI;
              ST_ADDR_HI: state_d = ST_ADDR_LO;
              ST_ADDR_LO: state_d = ST_TYPE;
              ST_TYPE:    state_d = ST_DATA;
              ST_DATA: begin
                if (CntW'(idx_q) + CntW'(1) == cnt_q) begin
                  state_d = ST_CHECK;
                end else begin
                  idx_d = idx_q + IdxW'(1);
                end
              end
              default:    state_d = crlf_i ? ST_CR : ST_LF;
            endcase
          end
        end
      end
      ST_CR: begin
        if (fire) begin
          state_d = ST_LF;
        end
      end
      ST_LF: begin
        if (fire) begin
          cnt_d   = '0;
          addr_d  = org_addr_q;
          sum_d   = org_sum_q;
          state_d = end_q ? ST_EOF_REC : ST_IDLE;
        end
      end
      ST_EOF_REC: begin
        if (fire) begin
          if (eof_cnt_q == EOF_ZEROS) begin
            state_d = crlf_i ? ST_EOF_CR : ST_EOF_LF;
          end else begin
            eof_cnt_d = eof_cnt_q + 4'd1;
          end
        end
      end
      ST_EOF_CR: begin
        if (fire) begin
          state_d = ST_EOF_LF;
        end
      end
      ST_EOF_LF: begin
        if (fire) begin
          state_d = ST_EOF_MARK;
        end
      end
      ST_EOF_MARK: begin
        if (fire) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      nib_q     <= 1'b0;
      idx_q     <= '0;
      eof_cnt_q <= 4'd0;
      cnt_q     <= '0;
      addr_q    <= 16'd0;
      sum_q     <= 8'd0;
      end_q     <= 1'b0;
      ov_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      nib_q     <= nib_d;
      idx_q     <= idx_d;
      eof_cnt_q <= eof_cnt_d;
      cnt_q     <= cnt_d;
      addr_q    <= addr_d;
      sum_q     <= sum_d;
      end_q     <= end_d;
      if (adv) begin
        ov_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    org_addr_q <= org_addr_d;
    org_sum_q  <= org_sum_d;
    if (fire) begin
      oc_q <= emit_char;
      ol_q <= emit_last;
    end
  end

  // Record buffer; read one index ahead so the data digits never wait
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[cnt_q[IdxW-1:0]] <= cmd_i.data;
    end
    rd_q <= mem_q[idx_d];
  end

endmodule

/* hdl/intel_hex_record_writer_top.sv */
// A byte that completes a record, an origin with bytes buffered, or an end request
// passes the queue, engine state and output registers before its first character;
// other requests emit nothing. Throughput: bytes buffer while idle; the single
// character sequencer then emits one per cycle to a ready sink, up to 45 a record.
// Reset: asynchronous, active low; clears the buffer count, address, sum and queue,
// and sets CR LF line ends.
module intel_hex_record_writer_top #(
  parameter int RECORD_BYTES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [1:0]  s_axis_tuser,  // [1:0] req_type
  input  logic [23:0] s_axis_tdata,  // [7:0] data_byte, [23:8] address
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [7:0] out_char
  output logic        m_axis_tlast,  // last_char
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ihw_pkg::*;

  logic crlf_q;
  logic push_valid, push_ready;
  cmd_t push_cmd;
  logic pop_valid, pop_ready;
  cmd_t pop_cmd;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_CRLF_ADDR) ? {31'd0, crlf_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crlf_q <= 1'b1;
    end else if (psel && penable && pwrite && pready && paddr == REG_CRLF_ADDR) begin
      crlf_q <= pwdata[0];
    end
  end

  ihw_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_cmd_o    (push_cmd)
  );

  ihw_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  ihw_back #(
    .RECORD_BYTES (RECORD_BYTES)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .crlf_i        (crlf_q),
    .cmd_valid_i   (pop_valid),
    .cmd_ready_o   (pop_ready),
    .cmd_i         (pop_cmd),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // A run of output ends only on a line feed or the end-of-file marker
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> (m_axis_tdata == CHAR_LF || m_axis_tdata == CHAR_EOF))
    else $error("tlast on a character other than LF or EOF marker");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata == CHAR_EOF |-> m_axis_tlast)
    else $error("EOF marker without tlast");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata == CHAR_CR |-> !m_axis_tlast)
    else $error("CR marked as last character");

  // A full queue always has a command on offer to the engine
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !push_ready |-> pop_valid)
    else $error("queue full but empty");

endmodule

/* sim/intel_hex_record_writer_checker.sv */
`timescale 1ns / 1ps
module intel_hex_record_writer_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [1:0]  s_tuser_i,   // [1:0] req_type
  input  logic [23:0] s_tdata_i,   // [7:0] data_byte, [23:8] address
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [7:0]  m_tdata_i,   // [7:0] out_char
  input  logic        m_tlast_i,   // last_char
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic        pready_i,
  output int          fail_count_o,
  output int          pending_o
);
  import ihw_pkg::*;

  localparam int RECORD_BYTES = 16;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } hex_char_t;

  hex_char_t   char_q[$];
  hex_char_t   line_q[$];
  logic [7:0]  rec_bytes [RECORD_BYTES];
  logic [4:0]  byte_cnt;
  logic [15:0] rec_addr;
  logic [7:0]  run_sum;
  logic        crlf;
  int          fails = 0;

  function automatic logic [7:0] nibble_ascii(input logic [3:0] v);
    return (v < 4'd10) ? 8'h30 + 8'(v) : 8'h41 + 8'(v) - 8'd10;
  endfunction

  task automatic put(input logic [7:0] c);
    line_q.push_back(hex_char_t'{c, 1'b0});
  endtask

  task automatic put_hex(input logic [7:0] v);
    put(nibble_ascii(v[7:4]));
    put(nibble_ascii(v[3:0]));
  endtask

  task automatic put_eol();
    if (crlf) begin
      put(CHAR_CR);
    end
    put(CHAR_LF);
  endtask

  // Emit the buffered record, if any, and open a new one at next_addr
  task automatic close_record(input logic [15:0] next_addr);
    logic [7:0] chk;
    if (byte_cnt != 5'd0) begin
      chk = 8'h00 - run_sum - {3'b000, byte_cnt};
      put(CHAR_COLON);
      put_hex({3'b000, byte_cnt});
      put_hex(rec_addr[15:8]);
      put_hex(rec_addr[7:0]);
      put_hex(REC_TYPE_DATA);
      for (int i = 0; i < int'(byte_cnt); i++) begin
        put_hex(rec_bytes[i]);
      end
      put_hex(chk);
      put_eol();
    end
    byte_cnt = 5'd0;
    rec_addr = next_addr;
    run_sum  = next_addr[15:8] + next_addr[7:0];
  endtask

  task automatic encode_request(input req_e req, input logic [7:0] d, input logic [15:0] a);
    line_q.delete();
    case (req)
      REQ_DATA: begin
        rec_bytes[byte_cnt[3:0]] = d;
        byte_cnt++;
        run_sum += d;
        // a full record restarts just past the byte that filled it
        if (int'(byte_cnt) >= RECORD_BYTES) begin
          close_record(a + 16'd1);
        end
      end
      REQ_ORIGIN: close_record(a);
      REQ_END: begin
        close_record(16'h0000);
        put(CHAR_COLON);
        repeat (int'(EOF_ZEROS)) put(CHAR_ZERO);
        put_eol();
        put(CHAR_EOF);
      end
      default: ;
    endcase
    if (line_q.size() > 0) begin
      line_q[line_q.size() - 1].last = 1'b1;
    end
    foreach (line_q[i]) begin
      char_q.push_back(line_q[i]);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    hex_char_t exp_c;
    if (!rst_ni) begin
      char_q.delete();
      byte_cnt = 5'd0;
      rec_addr = 16'h0000;
      run_sum  = 8'h00;
      crlf     = 1'b1;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (char_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected char, expected none, actual %h last %b",
                   $time, m_tdata_i, m_tlast_i);
        end else begin
          exp_c = char_q.pop_front();
          if (exp_c.ch !== m_tdata_i) begin
            fails++;
            $display("%0t: out_char expected %h, actual %h", $time, exp_c.ch, m_tdata_i);
          end
          if (exp_c.last !== m_tlast_i) begin
            fails++;
            $display("%0t: last_char expected %b, actual %b", $time, exp_c.last, m_tlast_i);
          end
        end
      end
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == REG_CRLF_ADDR) begin
        crlf = pwdata_i[0];
      end
      if (s_tvalid_i && s_tready_i) begin
        encode_request(req_e'(s_tuser_i), s_tdata_i[7:0], s_tdata_i[23:8]);
      end
    end
    pending_o    = char_q.size();
    fail_count_o = fails;
  end

endmodule

/* sim/intel_hex_record_writer_top_tb.sv */
`timescale 1ns / 1ps
module intel_hex_record_writer_top_tb;
  import ihw_pkg::*;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [1:0]  s_axis_tuser  = REQ_DATA;  // [1:0] req_type
  logic [23:0] s_axis_tdata  = '0;        // [7:0] data_byte, [23:8] address
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;              // [7:0] out_char
  logic        m_axis_tlast;              // last_char
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = REG_CRLF_ADDR;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  int src_gap_pct    = 0;
  int sink_stall_pct = 0;
  int fail_count;
  int pending;

  always #1 clk_i = ~clk_i;

  intel_hex_record_writer_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  intel_hex_record_writer_checker u_monitor (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tuser_i    (s_axis_tuser),
    .s_tdata_i    (s_axis_tdata),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .m_tlast_i    (m_axis_tlast),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .pready_i     (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  task automatic send_request(input req_e req, input logic [7:0] d, input logic [15:0] a);
    while ($urandom_range(99) < src_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {a, d};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Hold off the sender until every expected char has drained
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_crlf(input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_CRLF_ADDR;
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic random_traffic(input int n_items);
    int          sent;
    int          pick;
    int          run_len;
    logic [15:0] next_addr;
    sent      = 0;
    next_addr = 16'($urandom);
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        send_request(REQ_NONE, 8'($urandom), 16'($urandom));
        sent++;
      end else if (pick < 16) begin
        send_request(REQ_END, 8'($urandom), 16'($urandom));
        next_addr = 16'h0000;
        sent++;
      end else if (pick < 32) begin
        // bias some origins near the top so full records wrap the address
        next_addr = (pick < 22) ? 16'hFFF0 + 16'($urandom_range(15)) : 16'($urandom);
        send_request(REQ_ORIGIN, 8'($urandom), next_addr);
        sent++;
      end else begin
        run_len = $urandom_range(1, 24);
        if (run_len > n_items - sent) begin
          run_len = n_items - sent;
        end
        repeat (run_len) begin
          // mostly contiguous addresses, with a stray one now and then
          send_request(REQ_DATA, 8'($urandom),
                       ($urandom_range(9) == 0) ? 16'($urandom) : next_addr);
          next_addr++;
          sent++;
        end
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(REQ_NONE, 8'hFF, 16'hFFFF);
    send_request(REQ_ORIGIN, 8'h00, 16'h0000);
    send_request(REQ_END, 8'h00, 16'h0000);
    send_request(REQ_ORIGIN, 8'hA5, 16'hFFF0);
    // full record covering every hex digit; last byte sits at 0xFFFF
    for (int i = 0; i < 16; i++) begin
      send_request(REQ_DATA, 8'(i * 17), 16'hFFF0 + 16'(i));
    end
    send_request(REQ_DATA, 8'h80, 16'h0000);
    send_request(REQ_ORIGIN, 8'h00, 16'h1234);
    send_request(REQ_DATA, 8'h7F, 16'h1234);
    send_request(REQ_END, 8'hFF, 16'hFFFF);
    settle();

    // upper bits set, bit 0 clear: LF only
    write_crlf(32'hFFFF_FFFE);
    random_traffic(22);
    settle();

    src_gap_pct = 86;
    write_crlf(32'h0000_0003);
    random_traffic(22);
    settle();

    src_gap_pct    = 0;
    sink_stall_pct = 86;
    write_crlf(32'h0000_0000);
    random_traffic(22);
    settle();

    src_gap_pct    = 26;
    sink_stall_pct = 26;
    write_crlf(32'h0000_0001);
    random_traffic(22);
    settle();

    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/ihw_pkg.sv
hdl/ihw_front.sv
hdl/ihw_fifo.sv
hdl/ihw_back.sv
hdl/intel_hex_record_writer_top.sv
sim/intel_hex_record_writer_checker.sv
sim/intel_hex_record_writer_top_tb.sv
